// ===== hdl/ftt_pkg.sv =====
package ftt_pkg;

    // Width of the value, frequency and count fields on the ports.
    localparam int FIELD_W = 12;

    // Default sizes of the two stores.
    localparam int DEF_NUM_VALUES = 4096;
    localparam int DEF_MAX_COUNT  = 4095;

    // Operation codes; code 3 is unused and changes nothing.
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_OLDCNT,
        S_DROP,
        S_RAISE,
        S_QRES,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] frequency;
    } t_in;

    typedef struct packed {
        logic               present;
        logic [FIELD_W-1:0] value_count;
    } t_out;

    // Control and status of the shared step unit.
    typedef struct packed {
        logic dec;
    } t_step_ctl;

    typedef struct packed {
        logic is_zero;
        logic at_max;
    } t_step_flags;

endpackage

// ===== hdl/ftt_ram.sv =====
module ftt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ftt_step_unit.sv =====
module ftt_step_unit import ftt_pkg::*; #(
    parameter int W       = 13,
    parameter int MAX_VAL = DEF_MAX_COUNT
) (
    input  logic         [W-1:0] i_operand,
    input  t_step_ctl            i_ctl,
    output logic         [W-1:0] o_result,
    output t_step_flags          o_flags
);

    // One incrementer/decrementer shared by the count and the tally updates.
    assign o_result        = i_ctl.dec ? (i_operand - W'(1)) : (i_operand + W'(1));
    assign o_flags.is_zero = (i_operand == '0);
    assign o_flags.at_max  = (i_operand == W'(MAX_VAL));

endmodule

// ===== hdl/frequency_tally_tracker.sv =====
// Frequency tally tracker: a per-value occurrence count together with a tally
// of how many distinct values currently hold each count.
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one command per
// transaction: add one occurrence of a value, delete one occurrence, or ask
// whether any value has exactly a given count. The output channel (o_out_valid,
// i_out_stall, o_out_data) returns exactly one transaction per command, in order.
// Commands are handled one at a time by a small sequencer that drives a single
// shared increment/decrement unit against two single-port-read memories.
// An add or delete that changes a count passes through count read, old tally
// read and decrement, new tally read and increment, and result load before the
// next acceptance; an ignored add or delete skips the tally update, a query
// reads only its tally entry, and the unused operation code goes straight to
// the result load. The input stays stalled until the result is loaded.
// The two memory read latencies and the one shared step unit set these steps.
// After reset both memories are swept to zero, one entry per cycle; o_in_stall
// is high for that whole sweep.
// If the receiver stalls, the finished result waits in the output register and
// the sequencer holds its last step until the register can take the next one.
module frequency_tally_tracker import ftt_pkg::*; #(
    parameter int NUM_VALUES = DEF_NUM_VALUES,
    parameter int MAX_COUNT  = DEF_MAX_COUNT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // Value store address width, count width (also the tally store address
    // width), tally entry width, and the width of the shared step unit.
    localparam int VAW       = $clog2(NUM_VALUES);
    localparam int CW        = $clog2(MAX_COUNT + 1);
    localparam int TW        = $clog2(NUM_VALUES + 1);
    localparam int SW        = (CW > TW) ? CW : TW;
    localparam int TDEPTH    = MAX_COUNT + 1;
    localparam int CLR_DEPTH = (NUM_VALUES > TDEPTH) ? NUM_VALUES : TDEPTH;
    localparam int CLRW      = $clog2(CLR_DEPTH);

    t_state           r_state, n_state;
    t_in              r_item, n_item;
    logic [CW-1:0]    r_old, n_old;
    logic [CW-1:0]    r_new, n_new;
    logic             r_present, n_present;
    logic             r_clearing, n_clearing;
    logic [CLRW-1:0]  r_clr_idx, n_clr_idx;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic             w_vram_we;
    logic [VAW-1:0]   w_vram_waddr;
    logic [CW-1:0]    w_vram_wdata;
    logic [VAW-1:0]   w_vram_raddr;
    logic [CW-1:0]    w_vram_rdata;

    logic             w_tram_we;
    logic [CW-1:0]    w_tram_waddr;
    logic [TW-1:0]    w_tram_wdata;
    logic [CW-1:0]    w_tram_raddr;
    logic [TW-1:0]    w_tram_rdata;

    logic [SW-1:0]    w_step_in;
    logic [SW-1:0]    w_step_out;
    t_step_ctl        w_step_ctl;
    t_step_flags      w_step_flags;

    logic             w_accept;
    logic             w_val_ok;
    logic             w_freq_ok;
    logic             w_change;
    logic [31:0]      w_val_ext;
    logic [31:0]      w_freq_ext;
    logic [31:0]      w_clr_ext;
    logic [31:0]      w_new_ext;

    ftt_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_VALUES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_vram_we),
        .i_waddr (w_vram_waddr),
        .i_wdata (w_vram_wdata),
        .i_raddr (w_vram_raddr),
        .o_rdata (w_vram_rdata)
    );

    ftt_ram #(
        .WIDTH (TW),
        .DEPTH (TDEPTH)
    ) u_tally_ram (
        .i_clk   (i_clk),
        .i_we    (w_tram_we),
        .i_waddr (w_tram_waddr),
        .i_wdata (w_tram_wdata),
        .i_raddr (w_tram_raddr),
        .o_rdata (w_tram_rdata)
    );

    ftt_step_unit #(
        .W       (SW),
        .MAX_VAL (MAX_COUNT)
    ) u_step (
        .i_operand (w_step_in),
        .i_ctl     (w_step_ctl),
        .o_result  (w_step_out),
        .o_flags   (w_step_flags)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_clearing || (r_state != S_IDLE);

    // Range checks on the latched command; values beyond the store are ignored
    // and frequencies of zero or above MAX_COUNT are never present.
    assign w_val_ext  = 32'(r_item.value);
    assign w_freq_ext = 32'(r_item.frequency);
    assign w_clr_ext  = 32'(r_clr_idx);
    assign w_new_ext  = 32'(r_new);
    assign w_val_ok   = (w_val_ext < 32'(NUM_VALUES));
    assign w_freq_ok  = (w_freq_ext != 32'd0) && (w_freq_ext <= 32'(MAX_COUNT));

    // The step unit sees the old count while the count is read back, and a
    // tally entry in every other step.
    assign w_step_in = (r_state == S_OLDCNT) ? SW'(w_vram_rdata) : SW'(w_tram_rdata);

    // An add changes the count unless it is saturated; a delete unless it is zero.
    assign w_change = (r_item.func == OP_DEL) ? !w_step_flags.is_zero
                                              : !w_step_flags.at_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clearing  <= n_clearing;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_old     <= n_old;
        r_new     <= n_new;
        r_present <= n_present;
        r_out     <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_old        = r_old;
        n_new        = r_new;
        n_present    = r_present;
        n_clearing   = r_clearing;
        n_clr_idx    = r_clr_idx;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        w_vram_we    = 1'b0;
        w_vram_waddr = w_val_ext[VAW-1:0];
        w_vram_wdata = r_new;
        w_vram_raddr = w_val_ext[VAW-1:0];
        w_tram_we    = 1'b0;
        w_tram_waddr = r_old;
        w_tram_wdata = w_step_out[TW-1:0];
        w_tram_raddr = r_old;
        w_step_ctl   = '{dec: 1'b0};

        // Sweep both stores to zero after reset.
        if (r_clearing) begin
            w_vram_we    = (w_clr_ext < 32'(NUM_VALUES));
            w_vram_waddr = w_clr_ext[VAW-1:0];
            w_vram_wdata = '0;
            w_tram_we    = (w_clr_ext < 32'(TDEPTH));
            w_tram_waddr = w_clr_ext[CW-1:0];
            w_tram_wdata = '0;
            n_clr_idx    = r_clr_idx + CLRW'(1);
            if (w_clr_ext == 32'(CLR_DEPTH - 1)) begin
                n_clearing = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item    = i_in_data;
                    n_new     = '0;
                    n_present = 1'b0;
                    n_state   = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                w_tram_raddr = w_freq_ext[CW-1:0];
                if ((r_item.func inside {OP_ADD, OP_DEL}) && w_val_ok) begin
                    n_state = S_OLDCNT;
                end else if ((r_item.func == OP_QUERY) && w_freq_ok) begin
                    n_state = S_QRES;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_OLDCNT: begin
                w_step_ctl   = '{dec: (r_item.func == OP_DEL)};
                w_tram_raddr = w_vram_rdata;
                n_old        = w_vram_rdata;
                if (w_change) begin
                    n_new   = w_step_out[CW-1:0];
                    n_state = S_DROP;
                end else begin
                    n_new   = w_vram_rdata;
                    n_state = S_FINISH;
                end
            end
            S_DROP: begin
                // Tally of the old count comes down; the new count is stored.
                w_step_ctl   = '{dec: 1'b1};
                w_tram_we    = (r_old != '0) && !w_step_flags.is_zero;
                w_tram_waddr = r_old;
                w_vram_we    = 1'b1;
                w_tram_raddr = r_new;
                n_state      = S_RAISE;
            end
            S_RAISE: begin
                // Tally of the new count goes up; count zero keeps no tally.
                w_step_ctl   = '{dec: 1'b0};
                w_tram_we    = (r_new != '0);
                w_tram_waddr = r_new;
                n_state      = S_FINISH;
            end
            S_QRES: begin
                n_present = !w_step_flags.is_zero;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.present     = r_present;
                    n_out.value_count = w_new_ext[FIELD_W-1:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // No command is taken while the stores are being swept.
    a_no_accept_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> o_in_stall)
        else $error("command accepted during clearing sweep");

    // A query result never carries a count.
    a_query_no_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.present) |-> (o_out_data.value_count == '0))
        else $error("present result with nonzero count");

    // The sequencer leaves idle only on an accepted command.
    a_idle_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !w_accept) |=> (r_state == S_IDLE))
        else $error("sequencer started without a command");

    // Only one store write of a tally happens per step, and never to count zero
    // while raising.
    a_raise_not_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RAISE) && w_tram_we) |-> (w_tram_waddr != '0))
        else $error("tally raised for count zero");

endmodule
